FILE: rtl/bhc_pkg.sv
`default_nettype none
package bhc_pkg;

  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = QAW + 1;
  localparam int QSW       = QAW + 2;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 64;
  localparam int DIV_STEPS = 64;
  localparam int DCW       = $clog2(DIV_STEPS);

  localparam logic [31:0] T_FINE_OFS = 32'd128000;
  localparam logic [63:0] P_BASE     = 64'd1048576;
  localparam logic [63:0] P_SCALE    = 64'd3125;
  localparam logic [63:0] P_ONE47    = 64'h0000_8000_0000_0000;
  localparam logic [31:0] H_TF_OFS   = 32'd76800;
  localparam logic [31:0] H_MAX      = 32'd419430400;
  localparam logic [31:0] H_B_OFS    = 32'd2097152;
  localparam logic [31:0] H_RND_A    = 32'd16384;
  localparam logic [31:0] H_C_OFS    = 32'd32768;
  localparam logic [31:0] H_RND_B    = 32'd8192;
  localparam logic [31:0] T_RND      = 32'd128;

  typedef enum logic [CFG_AW-1:0] {
    REG_CAL_TEMP      = 3'd0,
    REG_CAL_PRESS_A   = 3'd1,
    REG_CAL_PRESS_B   = 3'd2,
    REG_CAL_PRESS_HUM = 3'd3,
    REG_CAL_HUM_B     = 3'd4,
    REG_HUM_EN        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [7:0]  h6;
    logic [15:0] h4;
    logic [15:0] h5;
    logic        hum_en;
  } cal_t;

  typedef struct packed {
    logic [31:0] tf;
    logic [31:0] tc;
    logic [19:0] ap;
    logic [15:0] ah;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  function automatic logic [31:0] sx16_32(input logic [15:0] v);
    sx16_32 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    sx16_64 = {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32_64(input logic [31:0] v);
    sx32_64 = {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sx8_64(input logic [7:0] v);
    sx8_64 = {{56{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bhc_fifo.sv
`default_nettype none
module bhc_fifo (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  bhc_pkg::q_entry_t         push_data,
  input  wire                       pop,
  output bhc_pkg::q_entry_t         head,
  output logic                      empty,
  output logic [bhc_pkg::QCW-1:0]   count
);
  import bhc_pkg::*;

  q_entry_t           entry_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r;
  logic [QAW-1:0]     rd_ptr_r;
  logic [QCW-1:0]     count_r;
  logic               do_pop;

  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign head   = entry_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bhc_mul.sv
`default_nettype none
module bhc_mul (
  input  wire                clk,
  input  wire                rst_n,
  input  bhc_pkg::mul_req_t  req,
  output bhc_pkg::mul_rsp_t  rsp
);
  import bhc_pkg::*;

  logic [1:0]  cnt_r;
  logic        busy_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod_nxt;

  always_comb begin
    case (cnt_r)
      2'd0: begin
        op_x = a_r[31:0];
        op_y = b_r[31:0];
      end
      2'd1: begin
        op_x = a_r[31:0];
        op_y = b_r[63:32];
      end
      default: begin
        op_x = a_r[63:32];
        op_y = b_r[31:0];
      end
    endcase
  end

  assign prod_nxt = op_x * op_y;

  assign rsp.busy = busy_r;
  assign rsp.done = busy_r && (cnt_r == 2'd3);
  assign rsp.p    = acc_r + {prod_r[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start && !busy_r) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      a_r    <= req.a;
      b_r    <= req.b;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 1'b1;
      prod_r <= prod_nxt;
      if (cnt_r == 2'd1) begin
        acc_r <= prod_r;
      end else if (cnt_r == 2'd2) begin
        acc_r <= acc_r + {prod_r[31:0], 32'd0};
      end
      if (cnt_r == 2'd3) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bhc_div.sv
`default_nettype none
module bhc_div (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [63:0] num,
  input  wire  [63:0] den,
  output logic        busy,
  output logic        done,
  output logic [63:0] quo
);
  import bhc_pkg::*;

  logic            busy_r;
  logic [DCW-1:0]  cnt_r;
  logic            neg_r;
  logic [63:0]     dvd_r;
  logic [63:0]     dvs_r;
  logic [63:0]     rem_r;
  logic [64:0]     shifted;
  logic            qbit;
  logic [64:0]     diff;
  logic [63:0]     qfin;

  assign shifted = {rem_r, dvd_r[63]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign qbit    = !diff[64];
  assign qfin    = {dvd_r[62:0], qbit};
  assign busy    = busy_r;
  assign done    = busy_r && (cnt_r == DCW'(DIV_STEPS - 1));
  assign quo     = neg_r ? (64'd0 - qfin) : qfin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start && !busy_r) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      neg_r  <= num[63] ^ den[63];
      dvd_r  <= num[63] ? (64'd0 - num) : num;
      dvs_r  <= den[63] ? (64'd0 - den) : den;
      rem_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      dvd_r <= qfin;
      rem_r <= qbit ? diff[63:0] : shifted[63:0];
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bhc_front.sv
`default_nettype none
module bhc_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  bhc_pkg::cal_t            cal,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [19:0]              in_raw_pressure,
  input  wire  [19:0]              in_raw_temperature,
  input  wire  [15:0]              in_raw_humidity,
  input  wire  [bhc_pkg::QCW-1:0]  q_count,
  output logic                     push,
  output bhc_pkg::q_entry_t        push_data
);
  import bhc_pkg::*;

  logic        s1_v_r, s2_v_r, s3_v_r;
  logic [31:0] s1_m1_r, s1_dd_r;
  logic [19:0] s1_ap_r, s2_ap_r, s3_ap_r;
  logic [15:0] s1_ah_r, s2_ah_r, s3_ah_r;
  logic [31:0] s2_v1_r, s2_m2_r;
  logic [31:0] s3_tf_r;
  logic [31:0] at;
  logic [31:0] t1;
  logic [31:0] x1;
  logic [31:0] dt;
  logic [31:0] m1;
  logic [31:0] dd;
  logic [31:0] v1;
  logic [31:0] dd_s;
  logic [31:0] m2;
  logic [31:0] v2;
  logic [31:0] tc_sum;
  logic [31:0] tc;
  logic [QSW-1:0] used;
  logic        acc;

  assign used     = QSW'(q_count) + QSW'(s1_v_r) + QSW'(s2_v_r) + QSW'(s3_v_r);
  assign in_ready = (used < QSW'(QDEPTH));
  assign acc      = in_valid && in_ready;

  assign at = {12'd0, in_raw_temperature};
  assign t1 = {16'd0, cal.t1};
  assign x1 = (at >> 3) - (t1 << 1);
  assign dt = (at >> 4) - t1;
  assign m1 = x1 * sx16_32(cal.t2);
  assign dd = dt * dt;

  assign v1   = $signed(s1_m1_r) >>> 11;
  assign dd_s = $signed(s1_dd_r) >>> 12;
  assign m2   = dd_s * sx16_32(cal.t3);

  assign v2     = $signed(s2_m2_r) >>> 14;
  assign tc_sum = (s3_tf_r << 2) + s3_tf_r + T_RND;
  assign tc     = $signed(tc_sum) >>> 8;

  assign push         = s3_v_r;
  assign push_data.tf = s3_tf_r;
  assign push_data.tc = tc;
  assign push_data.ap = s3_ap_r;
  assign push_data.ah = s3_ah_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_m1_r <= m1;
    s1_dd_r <= dd;
    s1_ap_r <= in_raw_pressure;
    s1_ah_r <= in_raw_humidity;
    s2_v1_r <= v1;
    s2_m2_r <= m2;
    s2_ap_r <= s1_ap_r;
    s2_ah_r <= s1_ah_r;
    s3_tf_r <= s2_v1_r + v2;
    s3_ap_r <= s2_ap_r;
    s3_ah_r <= s2_ah_r;
  end

endmodule
`default_nettype wire

FILE: rtl/bhc_back.sv
`default_nettype none
module bhc_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bhc_pkg::cal_t       cal,
  input  wire                 q_empty,
  input  bhc_pkg::q_entry_t   q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [31:0]         out_temperature_centi,
  output logic [31:0]         out_pressure_q24_8,
  output logic                out_pressure_valid,
  output logic [16:0]         out_humidity_q22_10,
  output logic                out_humidity_valid
);
  import bhc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, P_SQ, P_W2A, P_W2B, P_V1A, P_V1B, P_DEN, P_NUM, P_DIV,
    P_Q1, P_Q2, P_Q3, P_FIN, H_K, H_L, H_M, H_N, H_O, H_Q, H_R, H_S,
    H_CL, ST_DONE
  } state_t;

  state_t      state_r;
  logic [31:0] tf_r, tc_r;
  logic [19:0] ap_r;
  logic [15:0] ah_r;
  logic [63:0] w1_r, sq_r, w2_r, t_r, den_r, p_r;
  logic [31:0] pout_r;
  logic        pval_r;
  logic [31:0] ha_r, hb_r, hc_r, hv_r;
  logic [16:0] hout_r;
  logic        hen_r;
  logic        out_valid_r;
  logic [31:0] o_tc_r, o_p_r;
  logic        o_pv_r, o_hv_r;
  logic [16:0] o_h_r;

  mul_req_t    mreq;
  mul_rsp_t    mrsp;
  logic        is_mul;
  logic        div_start, div_busy, div_done;
  logic [63:0] div_q;

  logic [63:0] r;
  logic [31:0] r32;
  logic [63:0] r_asr8, r_asr33, r_asr25, r_asr19;
  logic [63:0] ps;
  logic [63:0] pnum;
  logic [63:0] pf_sum, pf_s8;
  logic [31:0] hv_v;
  logic [31:0] hk_sum, hk;
  logic [31:0] r32_asr10, r32_asr11, r32_asr7, r32_asr4;
  logic [31:0] ho_sum, ho;
  logic [31:0] hv_s;
  logic [31:0] hclamp;
  logic        slot_free;

  bhc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  bhc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (t_r),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  assign r   = mrsp.p;
  assign r32 = mrsp.p[31:0];

  assign r_asr8  = $signed(r) >>> 8;
  assign r_asr33 = $signed(r) >>> 33;
  assign r_asr25 = $signed(r) >>> 25;
  assign r_asr19 = $signed(r) >>> 19;
  assign ps      = $signed(p_r) >>> 13;
  assign pnum    = ((P_BASE - {44'd0, ap_r}) << 31) - w2_r;
  assign pf_sum  = p_r + w1_r + w2_r;
  assign pf_s8   = $signed(pf_sum) >>> 8;

  assign hv_v      = tf_r - H_TF_OFS;
  assign hk_sum    = ({16'd0, ah_r} << 14) - (sx16_32(cal.h4) << 20) - r32 + H_RND_A;
  assign hk        = $signed(hk_sum) >>> 15;
  assign r32_asr10 = $signed(r32) >>> 10;
  assign r32_asr11 = $signed(r32) >>> 11;
  assign r32_asr7  = $signed(r32) >>> 7;
  assign r32_asr4  = $signed(r32) >>> 4;
  assign ho_sum    = r32 + H_RND_B;
  assign ho        = $signed(ho_sum) >>> 14;
  assign hv_s      = $signed(hv_r) >>> 15;
  assign hclamp    = hv_r[31] ? 32'd0 : ((hv_r > H_MAX) ? H_MAX : hv_r);

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign div_start = (state_r == P_DIV) && !div_busy;

  always_comb begin
    is_mul = 1'b1;
    mreq.a = '0;
    mreq.b = '0;
    unique case (state_r)
      P_SQ:    begin mreq.a = w1_r;               mreq.b = w1_r;               end
      P_W2A:   begin mreq.a = sq_r;               mreq.b = sx16_64(cal.p6);    end
      P_W2B:   begin mreq.a = w1_r;               mreq.b = sx16_64(cal.p5);    end
      P_V1A:   begin mreq.a = sq_r;               mreq.b = sx16_64(cal.p3);    end
      P_V1B:   begin mreq.a = w1_r;               mreq.b = sx16_64(cal.p2);    end
      P_DEN:   begin mreq.a = P_ONE47 + t_r;      mreq.b = {48'd0, cal.p1};    end
      P_NUM:   begin mreq.a = pnum;               mreq.b = P_SCALE;            end
      P_Q1:    begin mreq.a = sx16_64(cal.p9);    mreq.b = ps;                 end
      P_Q2:    begin mreq.a = t_r;                mreq.b = ps;                 end
      P_Q3:    begin mreq.a = sx16_64(cal.p8);    mreq.b = p_r;                end
      H_K:     begin mreq.a = sx32_64(hv_v);      mreq.b = sx16_64(cal.h5);    end
      H_L:     begin mreq.a = sx32_64(hv_v);      mreq.b = sx8_64(cal.h6);     end
      H_M:     begin mreq.a = sx32_64(hv_v);      mreq.b = sx8_64(cal.h3);     end
      H_N:     begin mreq.a = sx32_64(hb_r);      mreq.b = sx32_64(hc_r);      end
      H_O:     begin mreq.a = sx32_64(hb_r);      mreq.b = sx16_64(cal.h2);    end
      H_Q:     begin mreq.a = sx32_64(ha_r);      mreq.b = sx32_64(hb_r);      end
      H_R:     begin mreq.a = sx32_64(hv_s);      mreq.b = sx32_64(hv_s);      end
      H_S:     begin mreq.a = sx32_64(hc_r);      mreq.b = {56'd0, cal.h1};    end
      default: begin is_mul = 1'b0;                                            end
    endcase
    mreq.start = is_mul && !mrsp.busy;
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = o_tc_r;
  assign out_pressure_q24_8    = o_p_r;
  assign out_pressure_valid    = o_pv_r;
  assign out_humidity_q22_10   = o_h_r;
  assign out_humidity_valid    = o_hv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            tf_r    <= q_head.tf;
            tc_r    <= q_head.tc;
            ap_r    <= q_head.ap;
            ah_r    <= q_head.ah;
            w1_r    <= sx32_64(q_head.tf) - {32'd0, T_FINE_OFS};
            hen_r   <= cal.hum_en;
            hout_r  <= '0;
            pout_r  <= '0;
            pval_r  <= 1'b0;
            state_r <= P_SQ;
          end
        end
        P_SQ: if (mrsp.done) begin
          sq_r    <= r;
          state_r <= P_W2A;
        end
        P_W2A: if (mrsp.done) begin
          w2_r    <= r;
          state_r <= P_W2B;
        end
        P_W2B: if (mrsp.done) begin
          w2_r    <= w2_r + (r << 17) + (sx16_64(cal.p4) << 35);
          state_r <= P_V1A;
        end
        P_V1A: if (mrsp.done) begin
          t_r     <= r_asr8;
          state_r <= P_V1B;
        end
        P_V1B: if (mrsp.done) begin
          t_r     <= t_r + (r << 12);
          state_r <= P_DEN;
        end
        P_DEN: if (mrsp.done) begin
          den_r <= r_asr33;
          if (r_asr33 == '0) begin
            state_r <= hen_r ? H_K : ST_DONE;
          end else begin
            state_r <= P_NUM;
          end
        end
        P_NUM: if (mrsp.done) begin
          t_r     <= r;
          state_r <= P_DIV;
        end
        P_DIV: if (div_done) begin
          p_r     <= div_q;
          state_r <= P_Q1;
        end
        P_Q1: if (mrsp.done) begin
          t_r     <= r;
          state_r <= P_Q2;
        end
        P_Q2: if (mrsp.done) begin
          w1_r    <= r_asr25;
          state_r <= P_Q3;
        end
        P_Q3: if (mrsp.done) begin
          w2_r    <= r_asr19;
          state_r <= P_FIN;
        end
        P_FIN: begin
          pout_r  <= 32'(pf_s8 + (sx16_64(cal.p7) << 4));
          pval_r  <= 1'b1;
          state_r <= hen_r ? H_K : ST_DONE;
        end
        H_K: if (mrsp.done) begin
          ha_r    <= hk;
          state_r <= H_L;
        end
        H_L: if (mrsp.done) begin
          hb_r    <= r32_asr10;
          state_r <= H_M;
        end
        H_M: if (mrsp.done) begin
          hc_r    <= r32_asr11 + H_C_OFS;
          state_r <= H_N;
        end
        H_N: if (mrsp.done) begin
          hb_r    <= r32_asr10 + H_B_OFS;
          state_r <= H_O;
        end
        H_O: if (mrsp.done) begin
          hb_r    <= ho;
          state_r <= H_Q;
        end
        H_Q: if (mrsp.done) begin
          hv_r    <= r32;
          state_r <= H_R;
        end
        H_R: if (mrsp.done) begin
          hc_r    <= r32_asr7;
          state_r <= H_S;
        end
        H_S: if (mrsp.done) begin
          hv_r    <= hv_r - r32_asr4;
          state_r <= H_CL;
        end
        H_CL: begin
          hout_r  <= hclamp[28:12];
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            o_tc_r      <= tc_r;
            o_p_r       <= pout_r;
            o_pv_r      <= pval_r;
            o_h_r       <= hout_r;
            o_hv_r      <= hen_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/baro_humidity_compensation_core.sv
`default_nettype none
// Integer compensation of one set of raw temperature, pressure and humidity
// readings per transfer, using calibration coefficients written beforehand
// through the cfg_ port. A front end runs the fine-temperature pipeline and
// queues up to four items, so in_ready stays high while the back end works
// until queue and front-end pipeline hold four items between them; the back
// end steps through pressure and humidity on one shared 32x32 multiplier and
// a one-bit-per-cycle 64-bit divider. An item stays longer in the back end
// with humidity enabled, and less when the pressure divisor is zero; the
// finished result sits in an output register until out_ready takes it.
module baro_humidity_compensation_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire  [bhc_pkg::CFG_AW-1:0]     cfg_index,
  input  wire  [bhc_pkg::CFG_DW-1:0]     cfg_wdata,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [19:0]                    in_raw_pressure,
  input  wire  [19:0]                    in_raw_temperature,
  input  wire  [15:0]                    in_raw_humidity,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [31:0]             out_temperature_centi,
  output logic [31:0]                    out_pressure_q24_8,
  output logic                           out_pressure_valid,
  output logic [16:0]                    out_humidity_q22_10,
  output logic                           out_humidity_valid
);
  import bhc_pkg::*;

  logic [47:0] cal_temp_r;
  logic [63:0] cal_press_a_r;
  logic [63:0] cal_press_b_r;
  logic [55:0] cal_press_hum_r;
  logic [31:0] cal_hum_b_r;
  logic        hum_en_r;
  cal_t        cal;

  logic        q_push, q_pop, q_empty;
  q_entry_t    q_in, q_head;
  logic [QCW-1:0] q_count;
  logic [31:0] tc_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r      <= '0;
      cal_press_a_r   <= '0;
      cal_press_b_r   <= '0;
      cal_press_hum_r <= '0;
      cal_hum_b_r     <= '0;
      hum_en_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_TEMP:      cal_temp_r      <= cfg_wdata[47:0];
        REG_CAL_PRESS_A:   cal_press_a_r   <= cfg_wdata;
        REG_CAL_PRESS_B:   cal_press_b_r   <= cfg_wdata;
        REG_CAL_PRESS_HUM: cal_press_hum_r <= cfg_wdata[55:0];
        REG_CAL_HUM_B:     cal_hum_b_r     <= cfg_wdata[31:0];
        REG_HUM_EN:        hum_en_r        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cal.t1     = cal_temp_r[15:0];
  assign cal.t2     = cal_temp_r[31:16];
  assign cal.t3     = cal_temp_r[47:32];
  assign cal.p1     = cal_press_a_r[15:0];
  assign cal.p2     = cal_press_a_r[31:16];
  assign cal.p3     = cal_press_a_r[47:32];
  assign cal.p4     = cal_press_a_r[63:48];
  assign cal.p5     = cal_press_b_r[15:0];
  assign cal.p6     = cal_press_b_r[31:16];
  assign cal.p7     = cal_press_b_r[47:32];
  assign cal.p8     = cal_press_b_r[63:48];
  assign cal.p9     = cal_press_hum_r[15:0];
  assign cal.h1     = cal_press_hum_r[23:16];
  assign cal.h2     = cal_press_hum_r[39:24];
  assign cal.h3     = cal_press_hum_r[47:40];
  assign cal.h6     = cal_press_hum_r[55:48];
  assign cal.h4     = cal_hum_b_r[15:0];
  assign cal.h5     = cal_hum_b_r[31:16];
  assign cal.hum_en = hum_en_r;

  bhc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cal                (cal),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_humidity    (in_raw_humidity),
    .q_count            (q_count),
    .push               (q_push),
    .push_data          (q_in)
  );

  bhc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  bhc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cal                   (cal),
    .q_empty               (q_empty),
    .q_head                (q_head),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (tc_out),
    .out_pressure_q24_8    (out_pressure_q24_8),
    .out_pressure_valid    (out_pressure_valid),
    .out_humidity_q22_10   (out_humidity_q22_10),
    .out_humidity_valid    (out_humidity_valid)
  );

  assign out_temperature_centi = $signed(tc_out);

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> q_count < QCW'(QDEPTH))
    else $error("queue overrun on input transfer");

  a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pressure_valid |-> out_pressure_q24_8 == 32'd0)
    else $error("pressure not zero with valid flag clear");

  a_hum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_humidity_valid |-> out_humidity_q22_10 == 17'd0)
    else $error("humidity not zero while disabled");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_q22_10 <= 17'd102400)
    else $error("humidity above full scale");

endmodule
`default_nettype wire
